[design/rfds_pkg.sv]
package rfds_pkg;

	localparam int THREADS = 16;
	localparam int TW      = $clog2(THREADS);
	localparam int CW      = $clog2(THREADS + 1);

	typedef enum logic [2:0] {
		OPC_READY = 3'd0,
		OPC_SLEEP = 3'd1,
		OPC_WAIT  = 3'd2,
		OPC_WAKE  = 3'd3,
		OPC_SCHED = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		OP_READY,
		OP_SLEEP,
		OP_WAIT,
		OP_WAKE,
		OP_SCHED,
		OP_BAD
	} op_t;

	typedef enum logic [2:0] {
		K_DONE     = 3'd0,
		K_ERROR    = 3'd1,
		K_WOKE     = 3'd2,
		K_TIMEOUT  = 3'd3,
		K_DISPATCH = 3'd4,
		K_IDLE     = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_FLOATING = 2'd0,
		ST_READY    = 2'd1,
		ST_SLEEPING = 2'd2,
		ST_WAITING  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INS,
		S_REM,
		S_SWEEP,
		S_POP,
		S_REPLY
	} state_t;

	typedef struct packed {
		op_t          op;
		logic [3:0]   tid;
		logic         wt_zero;
		logic [63:0]  dl;
		logic [63:0]  now;
		logic [63:0]  wake_value;
		logic         hr;
		logic [3:0]   rt;
	} cmd_t;

	typedef struct packed {
		logic valid;
	} cmd_hs_t;

endpackage

[design/rfds_front.sv]
module rfds_front import rfds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  operation,
	input  logic [3:0]  thread_id,
	input  logic [47:0] wait_time,
	input  logic [63:0] now_ns,
	input  logic [63:0] wake_value,
	input  logic        has_running,
	input  logic [3:0]  running_thread,
	input  logic        in_valid,
	output logic        in_ready,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  logic        cmd_pop
);

	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       c_d;
	logic       push;

	always_comb begin
		case (operation)
			OPC_READY: c_d.op = OP_READY;
			OPC_SLEEP: c_d.op = OP_SLEEP;
			OPC_WAIT:  c_d.op = OP_WAIT;
			OPC_WAKE:  c_d.op = OP_WAKE;
			OPC_SCHED: c_d.op = OP_SCHED;
			default:   c_d.op = OP_BAD;
		endcase
		c_d.tid        = thread_id;
		c_d.wt_zero    = (wait_time == '0);
		c_d.dl         = now_ns + {16'd0, wait_time};
		c_d.now        = now_ns;
		c_d.wake_value = wake_value;
		c_d.hr         = has_running;
		c_d.rt         = running_thread;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid & in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= c_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

[design/rfds_back.sv]
module rfds_back import rfds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  cmd_hs_t     hs_in,
	output logic        cmd_pop,
	output logic [2:0]  kind,
	output logic [3:0]  thread_out,
	output logic [63:0] value_out,
	output logic        last,
	output logic        out_valid,
	input  logic        out_ready
);

	state_t          state_q, nxt;
	cmd_t            cur_q;
	status_t         status_q [THREADS];
	logic [63:0]     dl_q [THREADS];
	logic [TW-1:0]   ring_q [THREADS];
	logic [TW-1:0]   order_q [THREADS];
	logic [TW-1:0]   head_q;
	logic [CW-1:0]   rc_q, sc_q, pos_q;
	kind_t           r_kind_q;
	logic [TW-1:0]   r_thr_q;
	logic [63:0]     r_val_q;

	logic            out_free;
	logic [TW-1:0]   stat_idx, head_thr, tail;
	status_t         stat_rd;
	logic [63:0]     dl_rd;
	logic            set_reply, emit_sweep, emit_reply;
	kind_t           r_kind, s_kind;
	logic [TW-1:0]   r_thr;
	logic [63:0]     r_val;
	logic            push_en, pop_en, ins_en, rem_en, pos_clr, pos_inc;
	logic [TW-1:0]   push_thr;
	logic            st_we0, st_we1;
	logic [TW-1:0]   st_idx0, st_idx1;
	status_t         st_val0, st_val1;

	assign out_free = !out_valid || out_ready;
	assign stat_rd  = status_q[stat_idx];
	assign dl_rd    = dl_q[order_q[pos_q[TW-1:0]]];
	assign head_thr = ring_q[head_q];
	assign tail     = head_q + rc_q[TW-1:0];

	always_comb begin
		nxt        = state_q;
		cmd_pop    = 1'b0;
		stat_idx   = cur_q.tid;
		set_reply  = 1'b0;
		r_kind     = K_ERROR;
		r_thr      = cur_q.tid;
		r_val      = '0;
		emit_sweep = 1'b0;
		emit_reply = 1'b0;
		s_kind     = K_WOKE;
		push_en    = 1'b0;
		push_thr   = cur_q.tid;
		pop_en     = 1'b0;
		ins_en     = 1'b0;
		rem_en     = 1'b0;
		pos_clr    = 1'b0;
		pos_inc    = 1'b0;
		st_we0     = 1'b0;
		st_idx0    = cur_q.tid;
		st_val0    = ST_READY;
		st_we1     = 1'b0;
		st_idx1    = cur_q.rt;
		st_val1    = ST_READY;
		case (state_q)
			S_IDLE: begin
				if (hs_in.valid) begin
					cmd_pop = 1'b1;
					nxt     = S_DECODE;
				end
			end
			S_DECODE: begin
				set_reply = 1'b1;
				nxt       = S_REPLY;
				case (cur_q.op)
					OP_READY: begin
						if (stat_rd == ST_FLOATING) begin
							r_kind  = K_DONE;
							push_en = 1'b1;
							st_we0  = 1'b1;
						end
					end
					OP_SLEEP, OP_WAIT: begin
						if (stat_rd == ST_FLOATING && !cur_q.wt_zero
						    && sc_q < CW'(THREADS)) begin
							set_reply = 1'b0;
							pos_clr   = 1'b1;
							nxt       = S_INS;
						end
					end
					OP_WAKE: begin
						if (stat_rd inside {ST_SLEEPING, ST_WAITING}) begin
							set_reply = 1'b0;
							pos_clr   = 1'b1;
							nxt       = S_REM;
						end
					end
					OP_SCHED: begin
						set_reply = 1'b0;
						pos_clr   = 1'b1;
						nxt       = S_SWEEP;
					end
					default: ;
				endcase
			end
			S_INS: begin
				// insert after every entry with an equal or earlier deadline
				if (pos_q < sc_q && !(cur_q.dl < dl_rd)) begin
					pos_inc = 1'b1;
				end else begin
					ins_en    = 1'b1;
					st_we0    = 1'b1;
					st_val0   = (cur_q.op == OP_SLEEP) ? ST_SLEEPING : ST_WAITING;
					set_reply = 1'b1;
					r_kind    = K_DONE;
					nxt       = S_REPLY;
				end
			end
			S_REM: begin
				if (order_q[pos_q[TW-1:0]] == cur_q.tid) begin
					rem_en    = 1'b1;
					st_we0    = 1'b1;
					push_en   = 1'b1;
					set_reply = 1'b1;
					r_kind    = K_DONE;
					r_val     = cur_q.wake_value;
					nxt       = S_REPLY;
				end else begin
					pos_inc = 1'b1;
				end
			end
			S_SWEEP: begin
				stat_idx = order_q[0];
				s_kind   = (stat_rd == ST_WAITING) ? K_TIMEOUT : K_WOKE;
				if (sc_q != '0 && dl_rd < cur_q.now) begin
					if (out_free) begin
						emit_sweep = 1'b1;
						rem_en     = 1'b1;
						st_we0     = 1'b1;
						st_idx0    = order_q[0];
						push_en    = 1'b1;
						push_thr   = order_q[0];
					end
				end else begin
					nxt = S_POP;
				end
			end
			S_POP: begin
				stat_idx  = cur_q.rt;
				set_reply = 1'b1;
				nxt       = S_REPLY;
				if (rc_q == '0) begin
					r_kind = K_IDLE;
					r_thr  = '0;
				end else if (cur_q.hr && stat_rd != ST_FLOATING && cur_q.rt != head_thr) begin
					r_thr = cur_q.rt;
				end else begin
					pop_en  = 1'b1;
					st_we0  = 1'b1;
					st_idx0 = head_thr;
					st_val0 = ST_FLOATING;
					if (cur_q.hr) begin
						push_en  = 1'b1;
						push_thr = cur_q.rt;
						st_we1   = 1'b1;
					end
					r_kind = K_DISPATCH;
					r_thr  = head_thr;
				end
			end
			S_REPLY: begin
				if (out_free) begin
					emit_reply = 1'b1;
					nxt        = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) status_q[i] <= ST_FLOATING;
			head_q    <= '0;
			rc_q      <= '0;
			sc_q      <= '0;
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (st_we0) status_q[st_idx0] <= st_val0;
			if (st_we1) status_q[st_idx1] <= st_val1;
			if (pop_en) head_q <= head_q + 1'b1;
			rc_q <= rc_q + CW'(push_en) - CW'(pop_en);
			sc_q <= sc_q + CW'(ins_en) - CW'(rem_en);
			if (pos_clr) pos_q <= '0;
			else if (pos_inc) pos_q <= pos_q + 1'b1;
			if (emit_sweep || emit_reply) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
		if (set_reply) begin
			r_kind_q <= r_kind;
			r_thr_q  <= r_thr;
			r_val_q  <= r_val;
		end
		if (push_en) ring_q[tail] <= push_thr;
		if (ins_en) begin
			dl_q[cur_q.tid] <= cur_q.dl;
			for (int i = 1; i < THREADS; i++) begin
				if (CW'(i) > pos_q) order_q[i] <= order_q[i-1];
			end
			for (int i = 0; i < THREADS; i++) begin
				if (CW'(i) == pos_q) order_q[i] <= cur_q.tid;
			end
		end else if (rem_en) begin
			for (int i = 0; i < THREADS - 1; i++) begin
				if (CW'(i) >= pos_q) order_q[i] <= order_q[i+1];
			end
		end
		if (emit_sweep) begin
			kind       <= s_kind;
			thread_out <= order_q[0];
			value_out  <= '0;
			last       <= 1'b0;
		end else if (emit_reply) begin
			kind       <= r_kind_q;
			thread_out <= r_thr_q;
			value_out  <= r_val_q;
			last       <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_threads_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rc_q + sc_q) <= CW'(THREADS))
		else $error("more threads queued than exist");
	a_rem_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REM |-> pos_q < sc_q)
		else $error("woken thread missing from sleep list");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_sweep || emit_reply) |-> out_free)
		else $error("result written over a pending transaction");
	a_sweep_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_sweep |=> out_valid && !last)
		else $error("swept result flagged last");
`endif

endmodule

[design/ready_fifo_with_deadline_sleep_queue.sv]
// Hardware thread scheduler with a FIFO ready queue and a deadline-sorted sleep list for
// 16 threads. Each operation yields one result with last=1, except schedule, which first
// yields one result per expired sleeper (last=0) and then a dispatch, idle or error result.
// A front stage decodes transactions and computes the deadline into a two-entry queue; a
// back sequencer executes them one at a time. Sleep/wait walk the sleep list entry by entry
// for sorted insertion, wake walks it up to the thread's position, and schedule emits the
// expired sleepers one by one before popping the ready queue or reporting idle or error.
module ready_fifo_with_deadline_sleep_queue import rfds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [3:0]  thread_id,
	input  logic [47:0] wait_time,
	input  logic [63:0] now_ns,
	input  logic [63:0] wake_value,
	input  logic        has_running,
	input  logic [3:0]  running_thread,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [3:0]  thread_out,
	output logic [63:0] value_out,
	output logic        last
);

	cmd_t    cmd;
	cmd_hs_t hs;
	logic    cmd_valid, cmd_pop;

	assign hs.valid = cmd_valid;

	rfds_front u_front (
		.clk, .arst_n, .operation, .thread_id, .wait_time, .now_ns, .wake_value,
		.has_running, .running_thread, .in_valid, .in_ready,
		.cmd, .cmd_valid, .cmd_pop
	);

	rfds_back u_back (
		.clk, .arst_n, .cmd, .hs_in(hs), .cmd_pop,
		.kind, .thread_out, .value_out, .last, .out_valid, .out_ready
	);

endmodule
